### design/ssp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_pkg
// Shared types, constants and arithmetic helpers of the spherical spiral
// point and tangent pipeline.
// ----------------------------------------------------------------------------
package ssp_pkg;

  localparam int FRAC_BITS_DEF     = 16;
  localparam int CORDIC_STAGES_DEF = 24;

  // 1/(2*pi) in Q32, pi/2 in Q30, cordic start gain in Q30
  localparam logic [29:0]        INV_2PI_Q32     = 30'd683565276;
  localparam logic [30:0]        HALF_PI_Q30     = 31'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

  localparam int SQ_STEPS = 31;
  localparam int DV_STEPS = 32;
  localparam int DV_LAT   = DV_STEPS + 1;

  localparam logic [1:0] REG_CENTER_X      = 2'd0;
  localparam logic [1:0] REG_CENTER_Y      = 2'd1;
  localparam logic [1:0] REG_CENTER_Z      = 2'd2;
  localparam logic [1:0] REG_SPHERE_RADIUS = 2'd3;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
  localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;
  localparam logic signed [67:0] RND_HALF_Q30 = 68'sd536870912;

  typedef struct packed {
    logic [30:0] lead;
    logic [30:0] angle;
  } in_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
    logic               fault;
  } out_t;

  typedef struct packed {
    logic               fault_h;
    logic               azero;
    logic               neg;
    logic [28:0]        dz;
    logic signed [31:0] pz;
    logic [60:0]        prod;
  } sq_side_t;

  typedef struct packed {
    logic               fault_h;
    logic               azero;
    logic               neg;
    logic [28:0]        dz;
    logic signed [31:0] pz;
    logic [30:0]        r;
  } dv_side_t;

  function automatic logic signed [32:0] atan_q30(input int i);
    logic signed [32:0] v;
    v = '0;
    case (i)
      0: v = 33'sd843314857;
      1: v = 33'sd497837829;
      2: v = 33'sd263043837;
      3: v = 33'sd133525159;
      4: v = 33'sd67021688;
      5: v = 33'sd33543515;
      6: v = 33'sd16775851;
      7: v = 33'sd8388437;
      8: v = 33'sd4194283;
      9: v = 33'sd2097149;
      10: v = 33'sd1048576;
      11: v = 33'sd524288;
      12: v = 33'sd262144;
      13: v = 33'sd131072;
      14: v = 33'sd65536;
      15: v = 33'sd32768;
      16: v = 33'sd16384;
      17: v = 33'sd8192;
      18: v = 33'sd4096;
      19: v = 33'sd2048;
      20: v = 33'sd1024;
      21: v = 33'sd512;
      22: v = 33'sd256;
      23: v = 33'sd128;
      24: v = 33'sd64;
      25: v = 33'sd32;
      26: v = 33'sd16;
      27: v = 33'sd8;
      28: v = 33'sd4;
      29: v = 33'sd2;
      30: v = 33'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] o;
    if (v > SAT_MAX) begin
      o = 32'sh7fffffff;
    end else if (v < SAT_MIN) begin
      o = 32'sh80000000;
    end else begin
      o = v[31:0];
    end
    return o;
  endfunction

  function automatic logic signed [67:0] rnd30(input logic signed [67:0] v);
    return (v + RND_HALF_Q30) >>> 30;
  endfunction

endpackage

### design/ssp_delay.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_delay
// Enabled shift line that aligns side data with the main pipeline.
// ----------------------------------------------------------------------------
module ssp_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] in_d,
  output logic [WIDTH-1:0] out_d
);

  logic [WIDTH-1:0] d_r [DEPTH];

  genvar k;
  for (k = 0; k < DEPTH; k++) begin : g_tap
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en) begin
          d_r[k] <= in_d;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (en) begin
          d_r[k] <= d_r[k-1];
        end
      end
    end
  end

  assign out_d = d_r[DEPTH-1];

endmodule

### design/ssp_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_cordic
// Rotation mode cordic, one iteration per stage, Q30 cos and sin with
// quadrant restore at the output.
// ----------------------------------------------------------------------------
module ssp_cordic #(
  parameter int STAGES = ssp_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] in_ang,
  input  logic [1:0]         in_quad,
  output logic signed [33:0] out_cos,
  output logic signed [33:0] out_sin
);

  logic signed [33:0] x_r [STAGES];
  logic signed [33:0] y_r [STAGES];
  logic signed [32:0] a_r [STAGES];
  logic [1:0]         q_r [STAGES];

  genvar k;
  for (k = 0; k < STAGES; k++) begin : g_iter
    logic signed [33:0] x_in;
    logic signed [33:0] y_in;
    logic signed [32:0] a_in;
    logic [1:0]         q_in;
    logic signed [33:0] xs;
    logic signed [33:0] ys;

    if (k == 0) begin : g_src0
      assign x_in = ssp_pkg::CORDIC_GAIN_Q30;
      assign y_in = '0;
      assign a_in = in_ang;
      assign q_in = in_quad;
    end else begin : g_srcn
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign a_in = a_r[k-1];
      assign q_in = q_r[k-1];
    end

    assign xs = x_in >>> k;
    assign ys = y_in >>> k;

    always_ff @(posedge clk) begin
      if (en) begin
        if (a_in >= 0) begin
          x_r[k] <= x_in - ys;
          y_r[k] <= y_in + xs;
          a_r[k] <= a_in - ssp_pkg::atan_q30(k);
        end else begin
          x_r[k] <= x_in + ys;
          y_r[k] <= y_in - xs;
          a_r[k] <= a_in + ssp_pkg::atan_q30(k);
        end
        q_r[k] <= q_in;
      end
    end
  end

  always_comb begin
    case (q_r[STAGES-1])
      ssp_pkg::QUAD_0: begin
        out_cos = x_r[STAGES-1];
        out_sin = y_r[STAGES-1];
      end
      ssp_pkg::QUAD_1: begin
        out_cos = -y_r[STAGES-1];
        out_sin = x_r[STAGES-1];
      end
      ssp_pkg::QUAD_2: begin
        out_cos = -x_r[STAGES-1];
        out_sin = -y_r[STAGES-1];
      end
      default: begin
        out_cos = y_r[STAGES-1];
        out_sin = -x_r[STAGES-1];
      end
    endcase
  end

endmodule

### design/ssp_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module ssp_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [61:0]       in_rad,
  input  ssp_pkg::sq_side_t in_side,
  output logic              out_valid,
  output logic [30:0]       out_root,
  output ssp_pkg::sq_side_t out_side
);

  localparam int N = ssp_pkg::SQ_STEPS;

  logic              v_r    [N];
  logic [31:0]       rem_r  [N];
  logic [30:0]       root_r [N];
  logic [61:0]       rad_r  [N];
  ssp_pkg::sq_side_t side_r [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_step
    logic              v_in;
    logic [31:0]       rem_in;
    logic [30:0]       root_in;
    logic [61:0]       rad_in;
    ssp_pkg::sq_side_t side_in;
    logic [33:0]       cur;
    logic [33:0]       test;
    logic [33:0]       diff;
    logic              ge;

    if (k == 0) begin : g_src0
      assign v_in    = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_srcn
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign cur  = {rem_in, rad_in[61:60]};
    assign test = {1'b0, root_in, 2'b01};
    assign diff = cur - test;
    assign ge   = cur >= test;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? diff[31:0] : cur[31:0];
        root_r[k] <= {root_in[29:0], ge};
        rad_r[k]  <= {rad_in[59:0], 2'b00};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_root  = root_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

### design/ssp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssp_div
// Pipelined restoring divider for the tangent lift term, rounded to
// nearest and clamped to 32 bits of magnitude.
// ----------------------------------------------------------------------------
module ssp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [60:0]       in_prod,
  input  ssp_pkg::dv_side_t in_side,
  output logic              out_valid,
  output logic [31:0]       out_mag,
  output ssp_pkg::dv_side_t out_side
);

  localparam int N = ssp_pkg::DV_STEPS;

  logic [60:0] num;
  logic        sat_nxt;

  logic              v0_r;
  logic              sat0_r;
  logic [31:0]       rem0_r;
  logic [31:0]       low0_r;
  ssp_pkg::dv_side_t side0_r;

  // numerator with half divisor for round to nearest
  assign num     = in_prod + {31'b0, in_side.r[30:1]};
  assign sat_nxt = {3'b0, num[60:32]} >= {1'b0, in_side.r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat0_r  <= sat_nxt;
      rem0_r  <= sat_nxt ? '0 : {3'b0, num[60:32]};
      low0_r  <= num[31:0];
      side0_r <= in_side;
    end
  end

  logic              v_r    [N];
  logic              sat_r  [N];
  logic [31:0]       rem_r  [N];
  logic [31:0]       low_r  [N];
  logic [31:0]       q_r    [N];
  ssp_pkg::dv_side_t side_r [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_step
    logic              v_in;
    logic              sat_in;
    logic [31:0]       rem_in;
    logic [31:0]       low_in;
    logic [31:0]       q_in;
    ssp_pkg::dv_side_t side_in;
    logic [32:0]       cur;
    logic [32:0]       dd;
    logic [32:0]       diff;
    logic              ge;

    if (k == 0) begin : g_src0
      assign v_in    = v0_r;
      assign sat_in  = sat0_r;
      assign rem_in  = rem0_r;
      assign low_in  = low0_r;
      assign q_in    = '0;
      assign side_in = side0_r;
    end else begin : g_srcn
      assign v_in    = v_r[k-1];
      assign sat_in  = sat_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign low_in  = low_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign cur  = {rem_in, low_in[31]};
    assign dd   = {2'b00, side_in.r};
    assign diff = cur - dd;
    assign ge   = cur >= dd;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sat_r[k]  <= sat_in;
        rem_r[k]  <= ge ? diff[31:0] : cur[31:0];
        low_r[k]  <= {low_in[30:0], 1'b0};
        q_r[k]    <= {q_in[30:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[N-1];
  assign out_mag   = sat_r[N-1] ? '1 : q_r[N-1];
  assign out_side  = side_r[N-1];

endmodule

### design/spherical_spiral_point_tangent_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spherical_spiral_point_tangent_top
// Point and tangent on a spiral wound over a configured sphere.
// ----------------------------------------------------------------------------
// Fully pipelined: one item is taken every clock while in_stall is low, and
// each result passes 7 front stages for rise, height, phase and squares,
// 31 square root stages, 33 divider stages, one product stage and the output
// register; the cordic runs beside the root and divider.
// A two-entry output buffer keeps taking items while a result waits; once
// both entries are full the whole pipeline holds and in_stall is raised.
// Configuration may only be written while no item is in flight.
module spherical_spiral_point_tangent_top #(
  parameter int FRAC_BITS     = ssp_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STAGES = ssp_pkg::CORDIC_STAGES_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ssp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output ssp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  localparam int Z_W    = 61 - FRAC_BITS;
  localparam int CS_DLY = 2 + ssp_pkg::SQ_STEPS + ssp_pkg::DV_LAT - CORDIC_STAGES;
  localparam logic [60:0] Z_HALF = 61'd1 << (FRAC_BITS - 1);
  localparam logic signed [31:0] TAN_ONE = 32'(64'd1 << FRAC_BITS);

  // configuration
  logic signed [31:0] cx_r;
  logic signed [31:0] cy_r;
  logic signed [31:0] cz_r;
  logic [30:0]        rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= '0;
      cy_r  <= '0;
      cz_r  <= '0;
      rad_r <= 31'(64'd1 << FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_index)
        ssp_pkg::REG_CENTER_X:      cx_r  <= cfg_wdata;
        ssp_pkg::REG_CENTER_Y:      cy_r  <= cfg_wdata;
        ssp_pkg::REG_CENTER_Z:      cz_r  <= cfg_wdata;
        ssp_pkg::REG_SPHERE_RADIUS: rad_r <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic skid_valid_r;
  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // f1: rise and phase products
  logic        v1_r;
  logic [60:0] dzp1_r;
  logic [63:0] php1_r;
  logic [30:0] ang1_r;

  // f2: rise per radian, phase in turns
  logic        v2_r;
  logic [28:0] dz2_r;
  logic [31:0] p2_r;
  logic [30:0] ang2_r;
  logic [60:0] dz_sum;

  // f3: height product, quadrant split
  logic        v3_r;
  logic [59:0] zp3_r;
  logic [1:0]  q3_r;
  logic        cneg3_r;
  logic [29:0] mag3_r;
  logic [28:0] dz3_r;
  logic [30:0] ang3_r;
  logic [31:0] qsum;
  logic [1:0]  q_nxt;
  logic [31:0] dres;
  logic [31:0] dmag;

  // f4: height, residual angle product
  logic           v4_r;
  logic [Z_W-1:0] z4_r;
  logic [60:0]    angp4_r;
  logic [1:0]     q4_r;
  logic           cneg4_r;
  logic [28:0]    dz4_r;
  logic           az4_r;
  logic [60:0]    zsum;

  // f5: sphere checks, cordic angle
  logic               v5_r;
  logic               fh5_r;
  logic               neg5_r;
  logic [30:0]        rr5_r;
  logic signed [31:0] pz5_r;
  logic [28:0]        dz5_r;
  logic               az5_r;
  logic signed [32:0] cang5_r;
  logic [1:0]         q5_r;
  logic [63:0]        zx;
  logic [63:0]        rx;
  logic [63:0]        rrw;
  logic [63:0]        pzs;
  logic               zneg;
  logic [60:0]        angsum;
  logic [32:0]        angm;

  // f6: squares and lift numerator
  logic               v6_r;
  logic [61:0]        big6_r;
  logic [61:0]        sml6_r;
  logic [60:0]        prod6_r;
  logic               fh6_r;
  logic               neg6_r;
  logic signed [31:0] pz6_r;
  logic [28:0]        dz6_r;
  logic               az6_r;

  // f7: root argument
  logic              v7_r;
  logic [61:0]       rad7_r;
  ssp_pkg::sq_side_t side7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  assign dz_sum = dzp1_r + 61'h80000000;

  assign qsum  = p2_r + 32'h20000000;
  assign q_nxt = qsum[31:30];
  assign dres  = p2_r - {q_nxt, 30'b0};
  assign dmag  = dres[31] ? (~dres + 32'd1) : dres;

  assign zsum = {1'b0, zp3_r} + Z_HALF;

  assign zx     = 64'(z4_r);
  assign rx     = {33'b0, rad_r};
  assign zneg   = zx > rx;
  assign rrw    = zneg ? (zx - rx) : (rx - zx);
  assign pzs    = zx + {{32{cz_r[31]}}, cz_r} - rx;
  assign angsum = angp4_r + 61'h20000000;
  assign angm   = {2'b00, angsum[60:30]};

  always_ff @(posedge clk) begin
    if (en) begin
      dzp1_r <= in_data.lead * ssp_pkg::INV_2PI_Q32;
      php1_r <= {33'b0, in_data.angle} * {34'b0, ssp_pkg::INV_2PI_Q32};
      ang1_r <= in_data.angle;

      dz2_r  <= dz_sum[60:32];
      p2_r   <= php1_r[FRAC_BITS +: 32];
      ang2_r <= ang1_r;

      zp3_r   <= ang2_r * dz2_r;
      q3_r    <= q_nxt;
      cneg3_r <= dres[31];
      mag3_r  <= dmag[29:0];
      dz3_r   <= dz2_r;
      ang3_r  <= ang2_r;

      z4_r    <= Z_W'(zsum >> FRAC_BITS);
      angp4_r <= mag3_r * ssp_pkg::HALF_PI_Q30;
      q4_r    <= q3_r;
      cneg4_r <= cneg3_r;
      dz4_r   <= dz3_r;
      az4_r   <= (ang3_r == '0);

      fh5_r   <= zx > {rx[62:0], 1'b0};
      neg5_r  <= zneg;
      rr5_r   <= rrw[30:0];
      pz5_r   <= ssp_pkg::sat32({{4{pzs[63]}}, pzs});
      dz5_r   <= dz4_r;
      az5_r   <= az4_r;
      cang5_r <= cneg4_r ? -$signed(angm) : $signed(angm);
      q5_r    <= q4_r;

      big6_r  <= rad_r * rad_r;
      sml6_r  <= rr5_r * rr5_r;
      prod6_r <= rr5_r * dz5_r;
      fh6_r   <= fh5_r;
      neg6_r  <= neg5_r;
      pz6_r   <= pz5_r;
      dz6_r   <= dz5_r;
      az6_r   <= az5_r;

      rad7_r          <= big6_r - sml6_r;
      side7_r.fault_h <= fh6_r;
      side7_r.azero   <= az6_r;
      side7_r.neg     <= neg6_r;
      side7_r.dz      <= dz6_r;
      side7_r.pz      <= pz6_r;
      side7_r.prod    <= prod6_r;
    end
  end

  // cos and sin of the angle
  logic signed [33:0] cos_c;
  logic signed [33:0] sin_c;
  logic [67:0]        cs_d;

  ssp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .en      (en),
    .in_ang  (cang5_r),
    .in_quad (q5_r),
    .out_cos (cos_c),
    .out_sin (sin_c)
  );

  ssp_delay #(
    .WIDTH (68),
    .DEPTH (CS_DLY)
  ) u_cs_dly (
    .clk   (clk),
    .en    (en),
    .in_d  ({cos_c, sin_c}),
    .out_d (cs_d)
  );

  // ring radius
  logic              sq_valid;
  logic [30:0]       sq_root;
  ssp_pkg::sq_side_t sq_side;
  ssp_pkg::dv_side_t dv_in_side;

  ssp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v7_r),
    .in_rad    (rad7_r),
    .in_side   (side7_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign dv_in_side.fault_h = sq_side.fault_h;
  assign dv_in_side.azero   = sq_side.azero;
  assign dv_in_side.neg     = sq_side.neg;
  assign dv_in_side.dz      = sq_side.dz;
  assign dv_in_side.pz      = sq_side.pz;
  assign dv_in_side.r       = sq_root;

  // lift term magnitude
  logic              dv_valid;
  logic [31:0]       dv_mag;
  ssp_pkg::dv_side_t dv_side;

  ssp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_prod   (sq_side.prod),
    .in_side   (dv_in_side),
    .out_valid (dv_valid),
    .out_mag   (dv_mag),
    .out_side  (dv_side)
  );

  // b1: tangent and position products
  logic signed [33:0] a1;
  logic signed [33:0] rsig;
  logic signed [33:0] cv;
  logic signed [33:0] sv;

  assign a1   = dv_side.neg ? -$signed({2'b00, dv_mag}) : $signed({2'b00, dv_mag});
  assign rsig = $signed({3'b000, dv_side.r});
  assign cv   = cs_d[67:34];
  assign sv   = cs_d[33:0];

  logic               b1_v_r;
  logic signed [67:0] rc_r;
  logic signed [67:0] rs_r;
  logic signed [67:0] ac_r;
  logic signed [67:0] as_r;
  logic               b1_fh_r;
  logic               b1_az_r;
  logic               b1_rz_r;
  logic signed [31:0] b1_pz_r;
  logic [28:0]        b1_dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rc_r    <= rsig * cv;
      rs_r    <= rsig * sv;
      ac_r    <= a1 * cv;
      as_r    <= a1 * sv;
      b1_fh_r <= dv_side.fault_h;
      b1_az_r <= dv_side.azero;
      b1_rz_r <= (dv_side.r == '0);
      b1_pz_r <= dv_side.pz;
      b1_dz_r <= dv_side.dz;
    end
  end

  // final sums and special cases
  ssp_pkg::out_t res_nxt;

  always_comb begin
    res_nxt = '0;
    if (b1_fh_r) begin
      res_nxt.fault = 1'b1;
    end else begin
      res_nxt.pos_x = ssp_pkg::sat32(ssp_pkg::rnd30(rc_r) + {{36{cx_r[31]}}, cx_r});
      res_nxt.pos_y = ssp_pkg::sat32(ssp_pkg::rnd30(rs_r) + {{36{cy_r[31]}}, cy_r});
      res_nxt.pos_z = b1_pz_r;
      if (b1_az_r) begin
        res_nxt.tan_x = TAN_ONE;
      end else if (b1_rz_r) begin
        res_nxt.fault = 1'b1;
      end else begin
        res_nxt.tan_x = ssp_pkg::sat32(ssp_pkg::rnd30(ac_r - rs_r));
        res_nxt.tan_y = ssp_pkg::sat32(ssp_pkg::rnd30(as_r + rc_r));
        res_nxt.tan_z = $signed({3'b000, b1_dz_r});
      end
    end
  end

  // output register with skid entry
  logic          push;
  logic          pop;
  logic          out_valid_r;
  ssp_pkg::out_t out_data_r;
  ssp_pkg::out_t skid_data_r;

  assign push = en && b1_v_r;
  assign pop  = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || pop) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_nxt;
    end
    if (out_valid_r && !pop && push) begin
      skid_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without output item");

  a_push_held_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !pop) |=> skid_valid_r)
    else $error("item pushed while output held was not kept");

  a_fault_zero_tangent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.fault) |->
      (out_data_r.tan_x == '0 && out_data_r.tan_y == '0 && out_data_r.tan_z == '0))
    else $error("fault item carries a tangent");

endmodule
